// File: rtl/timer_slot_scheduler_unit_assert.svh
// Assertion macros shared by the timer slot scheduler RTL.
`ifndef TIMER_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define TIMER_SLOT_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer slot scheduler: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer slot scheduler: next-cycle check failed");

`endif

// File: rtl/tss_pkg.sv
// Package with field widths, operation codes and status codes of the timer slot scheduler.
package tss_pkg;

    localparam int OP_W      = 3;
    localparam int DELAY_W   = 31;
    localparam int TAG_W     = 32;
    localparam int ID_W      = 7;
    localparam int ELAPSED_W = 16;
    localparam int STATUS_W  = 2;
    localparam int REM_W     = 31;
    localparam int TIME_W    = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RUN      = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

endpackage

// File: rtl/tss_if.sv
// Request and response channel interfaces of the timer slot scheduler.
interface tss_req_if import tss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [DELAY_W-1:0]   delay_ms;
    logic [TAG_W-1:0]     tag;
    logic [ID_W-1:0]      slot_id;
    logic [ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, op, delay_ms, tag, slot_id, elapsed_ms, input ready);
    modport sink   (input valid, op, delay_ms, tag, slot_id, elapsed_ms, output ready);
endinterface

interface tss_rsp_if import tss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     slot_out;
    logic [TAG_W-1:0]    tag_out;
    logic [REM_W-1:0]    remaining_ms;
    logic                table_full;

    modport source (output valid, status, slot_out, tag_out, remaining_ms, table_full,
                    input ready);
    modport sink   (input valid, status, slot_out, tag_out, remaining_ms, table_full,
                    output ready);
endinterface

// File: rtl/tss_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/timer_slot_scheduler_unit.sv
// Top level of the timer slot scheduler: control, busy flags, time counter and timer memory.
//
//  channel | role   | handshake   | payload
//  --------+--------+-------------+--------------------------------------------------
//  req     | sink   | valid/ready | op, delay_ms, tag, slot_id, elapsed_ms
//  rsp     | source | valid/ready | status, slot_out, tag_out, remaining_ms, table_full
//
// One request is worked on at a time; req.ready is high only while the block is idle.
// Next reads one timer entry per cycle across the table; run stops at the first due timer.
// Schedule scans the busy flags for a free slot. Delete goes through S_DEL, but not for
// slot 0 or a bad id; advance and undefined ops go straight to S_DONE. A result waits
// in the output register while the next request is taken; a second one holds the block
// until it drains. Reset clears state, time, busy flags, busy count and output valid only.
`include "timer_slot_scheduler_unit_assert.svh"

module timer_slot_scheduler_unit import tss_pkg::*; #(
    parameter int SLOTS = 128
) (
    input  logic  clk,
    input  logic  rst_n,
    tss_req_if.sink   req,
    tss_rsp_if.source rsp
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int ENTRY_W = TIME_W + TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX  = IDX_W'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FREE = 5'b00010,
        S_DEL  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SLOTS-1:0]    busy_reg, busy_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_slot_reg, res_slot_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic [REM_W-1:0]    res_rem_reg, res_rem_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_slot_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [REM_W-1:0]    out_rem_reg;
    logic                out_full_reg;
    logic                load_out;

    logic                mem_we;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    logic [TIME_W-1:0]   entry_expiry;
    logic [TAG_W-1:0]    entry_tag;
    logic                entry_busy;
    logic [TIME_W-1:0]   since_expiry;
    logic [TIME_W-1:0]   until_expiry;
    logic                entry_due;
    logic [REM_W-1:0]    entry_rem;
    logic                scan_last;
    logic [IDX_W:0]      scan_idx_inc;
    logic                req_xfer;
    logic                slot_claim;
    logic                run_fire;

    // Timer entries: expiry in the upper half, tag in the lower half.
    tss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (scan_idx_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;

    // Per-entry evaluation for the scans; comparisons wrap around modulo 2^32.
    assign entry_expiry = mem_rdata[ENTRY_W-1:TAG_W];
    assign entry_tag    = mem_rdata[TAG_W-1:0];
    assign entry_busy   = busy_reg[scan_idx_reg];
    assign since_expiry = now_reg - entry_expiry;
    assign until_expiry = entry_expiry - now_reg;
    assign entry_due    = !since_expiry[TIME_W-1];
    assign entry_rem    = until_expiry[TIME_W-1] ? '0 : until_expiry[REM_W-1:0];
    assign scan_last    = (scan_idx_reg == LAST_IDX);
    assign scan_idx_inc = {1'b0, scan_idx_reg} + 1'b1;
    assign mem_wdata    = {now_reg + {1'b0, delay_reg}, tag_reg};

    // Slot claim and run firing events, as seen by the checks below.
    assign slot_claim = (state_reg == S_FREE) && !entry_busy;
    assign run_fire   = (state_reg == S_SCAN) && (op_reg == OP_RUN) && entry_busy && entry_due;

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Sequencer: decode on transfer, scan slots, then hand the result over.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        delay_next      = delay_reg;
        tag_next        = tag_reg;
        now_next        = now_reg;
        busy_next       = busy_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_tag_next    = res_tag_reg;
        res_rem_next    = res_rem_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = scan_idx_inc[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next       = req.op;
                    delay_next    = req.delay_ms;
                    tag_next      = req.tag;
                    res_slot_next = '0;
                    res_tag_next  = '0;
                    res_rem_next  = '0;
                    if ((req.op == OP_RUN) || (req.op == OP_NEXT))
                    begin
                        res_status_next = ST_NONE;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                    end
                    state_next = S_DONE;
                    case (req.op)
                        OP_SCHEDULE:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                scan_idx_next = FIRST_IDX;
                                state_next    = S_FREE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (32'(req.slot_id) >= 32'(SLOTS))
                            begin
                                res_status_next = ST_BAD;
                            end
                            else if (req.slot_id != '0)
                            begin
                                scan_idx_next = IDX_W'(req.slot_id);
                                state_next    = S_DEL;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            now_next = now_reg + TIME_W'(req.elapsed_ms);
                        end
                        OP_RUN, OP_NEXT:
                        begin
                            mem_re        = 1'b1;
                            mem_raddr     = FIRST_IDX;
                            scan_idx_next = FIRST_IDX;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                // The table is known not to be full, so a free slot turns up.
                if (!entry_busy)
                begin
                    mem_we                  = 1'b1;
                    busy_next[scan_idx_reg] = 1'b1;
                    count_next              = count_reg + 1'b1;
                    res_slot_next           = ID_W'(scan_idx_reg);
                    state_next              = S_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_inc[IDX_W-1:0];
                end
            end
            S_DEL:
            begin
                if (entry_busy)
                begin
                    busy_next[scan_idx_reg] = 1'b0;
                    count_next              = count_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (op_reg == OP_RUN)
                begin
                    if (entry_busy && entry_due)
                    begin
                        busy_next[scan_idx_reg] = 1'b0;
                        count_next              = count_reg - 1'b1;
                        res_status_next         = ST_OK;
                        res_slot_next           = ID_W'(scan_idx_reg);
                        res_tag_next            = entry_tag;
                        state_next              = S_DONE;
                    end
                    else if (scan_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        scan_idx_next = scan_idx_inc[IDX_W-1:0];
                    end
                end
                else
                begin
                    // Running minimum; status turns OK at the first busy slot.
                    if (entry_busy && ((res_status_reg != ST_OK) || (entry_rem < res_rem_reg)))
                    begin
                        res_rem_next    = entry_rem;
                        res_status_next = ST_OK;
                    end
                    if (scan_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        scan_idx_next = scan_idx_inc[IDX_W-1:0];
                    end
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on a load, cleared when the result is transferred.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            busy_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        delay_reg      <= delay_next;
        tag_reg        <= tag_next;
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_tag_reg    <= res_tag_next;
        res_rem_reg    <= res_rem_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_tag_reg    <= res_tag_reg;
            out_rem_reg    <= res_rem_reg;
            out_full_reg   <= (count_reg == FULL_COUNT);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot_out     = out_slot_reg;
    assign rsp.tag_out      = out_tag_reg;
    assign rsp.remaining_ms = out_rem_reg;
    assign rsp.table_full   = out_full_reg;

    // Slot 0 is never handed out.
    `TSS_ASSERT_IMPLIES(a_slot0_free, clk, rst_n, 1'b1, !busy_reg[0])
    // A free-slot scan only starts when the busy count leaves room.
    `TSS_ASSERT_IMPLIES(a_free_scan_room, clk, rst_n, state_reg == S_FREE, count_reg != FULL_COUNT)
    // Claiming a slot raises the busy count by one.
    `TSS_ASSERT_NEXT(a_claim_counts, clk, rst_n, slot_claim, count_reg == $past(count_reg) + 1'b1)
    // A run that fires frees the slot and finishes.
    `TSS_ASSERT_NEXT(a_run_frees, clk, rst_n, run_fire, !busy_reg[$past(scan_idx_reg)] && (state_reg == S_DONE))

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timer slot scheduler: random and directed timer traffic.
module tb_top;
    import tss_pkg::*;

    localparam int SLOTS        = 128;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    // A run or next may scan every slot, so the tail covers two full scans.
    localparam int TAIL_CYCLES  = 2 * SLOTS + 20;
    localparam int RANDOM_ITEMS = 1650;
    // Full-size advances that walk the time counter toward the long timers.
    localparam int WRAP_STEPS   = 96;
    // Watchdog limit: the slowest legal run, taken about five times over.
    localparam longint LIMIT_NS = 64'd5_000_000;
    localparam int MAX_PRINTS   = 50;

    localparam logic [OP_W-1:0]   OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0]   OP_UNDEF_HI = 3'd7;
    localparam logic [TIME_W-1:0] HALF_RANGE  = 32'h8000_0000;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [DELAY_W-1:0]   delay_ms;
        logic [TAG_W-1:0]     tag;
        logic [ID_W-1:0]      slot_id;
        logic [ELAPSED_W-1:0] elapsed_ms;
        int                   gap;
        bit                   drain_first;
    } timer_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     slot_out;
        logic [TAG_W-1:0]    tag_out;
        logic [REM_W-1:0]    remaining_ms;
        logic                table_full;
    } timer_rsp_t;

    logic clk;
    logic rst_n;

    tss_req_if req_ch ();
    tss_rsp_if rsp_ch ();

    timer_slot_scheduler_unit #(
        .SLOTS (SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the timer table.
    logic [TIME_W-1:0] table_now;
    bit                table_busy   [SLOTS];
    logic [TIME_W-1:0] table_expiry [SLOTS];
    logic [TAG_W-1:0]  table_tag    [SLOTS];

    timer_cmd_t pending_cmds [$];
    timer_rsp_t expected_rsps [$];
    timer_cmd_t cur_cmd;

    int queued_count;
    int sent_total;
    int resp_total;
    int idle_waited;
    int stall_left;
    int error_count;
    int fired_count;
    int refused_count;
    int wrap_count;
    int op_seen [8];

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #LIMIT_NS;
        $display("Timeout: %0d of %0d requests answered", resp_total, queued_count);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int lowest_free_slot();
        int i;
        for (i = 1; i < SLOTS; i++)
        begin
            if (!table_busy[i])
                return i;
        end
        return 0;
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic timer_rsp_t apply_timer_cmd(timer_cmd_t cmd);
        timer_rsp_t        r;
        int                s;
        bit                hit;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] best;
        logic [TIME_W:0]   wide;
        r.status       = ST_OK;
        r.slot_out     = '0;
        r.tag_out      = '0;
        r.remaining_ms = '0;
        hit            = 1'b0;
        best           = '0;
        case (cmd.op)
            OP_SCHEDULE:
            begin
                s = lowest_free_slot();
                if (s == 0)
                begin
                    r.status = ST_FULL;
                    refused_count++;
                end
                else
                begin
                    table_busy[s]   = 1'b1;
                    table_expiry[s] = table_now + cmd.delay_ms;
                    table_tag[s]    = cmd.tag;
                    r.slot_out      = ID_W'(s);
                end
            end
            OP_DELETE:
            begin
                if (cmd.slot_id >= SLOTS)
                    r.status = ST_BAD;
                else if (cmd.slot_id != 0)
                    table_busy[cmd.slot_id] = 1'b0;
            end
            OP_ADVANCE:
            begin
                wide = {1'b0, table_now} + cmd.elapsed_ms;
                if (wide[TIME_W])
                    wrap_count++;
                table_now = wide[TIME_W-1:0];
            end
            OP_RUN:
            begin
                // Fire the lowest busy slot that is due, wrap-aware.
                r.status = ST_NONE;
                for (s = 1; s < SLOTS; s++)
                begin
                    if (!hit && table_busy[s] && (table_now - table_expiry[s]) < HALF_RANGE)
                    begin
                        hit           = 1'b1;
                        table_busy[s] = 1'b0;
                        r.status      = ST_OK;
                        r.slot_out    = ID_W'(s);
                        r.tag_out     = table_tag[s];
                        fired_count++;
                    end
                end
            end
            OP_NEXT:
            begin
                // Earliest expiry; timers already due count as zero.
                for (s = 1; s < SLOTS; s++)
                begin
                    if (table_busy[s])
                    begin
                        d = table_expiry[s] - table_now;
                        if (d >= HALF_RANGE)
                            d = '0;
                        if (!hit || d < best)
                            best = d;
                        hit = 1'b1;
                    end
                end
                if (hit)
                    r.remaining_ms = best[REM_W-1:0];
                else
                    r.status = ST_NONE;
            end
            default:
            begin
            end
        endcase
        r.table_full = (lowest_free_slot() == 0);
        return r;
    endfunction

    function automatic logic [DELAY_W-1:0] rand_delay();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DELAY_W'($urandom_range(0, 300));
            4, 5:       return DELAY_W'($urandom_range(0, 200000));
            6:          return {DELAY_W{1'b1}} - DELAY_W'($urandom_range(0, 3));
            default:    return DELAY_W'($urandom());
        endcase
    endfunction

    function automatic logic [ELAPSED_W-1:0] rand_elapsed();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ELAPSED_W'($urandom_range(0, 100));
            5:             return {ELAPSED_W{1'b1}};
            default:       return ELAPSED_W'($urandom());
        endcase
    endfunction

    function automatic logic [OP_W-1:0] OP_Format_undef();
        return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    endfunction

    // Appends one request; every fifth stretch of 160 requests goes out back to back.
    task automatic queue_cmd(logic [OP_W-1:0] op, logic [DELAY_W-1:0] delay,
                             logic [TAG_W-1:0] tag, logic [ID_W-1:0] id,
                             logic [ELAPSED_W-1:0] elapsed, bit drain);
        timer_cmd_t c;
        c.op          = op;
        c.delay_ms    = delay;
        c.tag         = tag;
        c.slot_id     = id;
        c.elapsed_ms  = elapsed;
        c.gap         = ((queued_count / 160) % 5 == 2) ? 0 : $urandom_range(0, 3);
        c.drain_first = drain;
        pending_cmds.push_back(c);
        queued_count++;
    endtask

    // One request of mixed traffic; fields the op ignores carry random noise.
    task automatic queue_random_cmd();
        logic [OP_W-1:0]      op;
        logic [DELAY_W-1:0]   delay;
        logic [ID_W-1:0]      id;
        logic [ELAPSED_W-1:0] elapsed;
        int                   pick;
        pick    = $urandom_range(0, 99);
        delay   = DELAY_W'($urandom());
        id      = ID_W'($urandom());
        elapsed = ELAPSED_W'($urandom());
        if (pick < 34)
        begin
            op    = OP_SCHEDULE;
            delay = rand_delay();
        end
        else if (pick < 50)
        begin
            op = OP_DELETE;
            // Low slots are the ones that get allocated, so most deletes hit them.
            case ($urandom_range(0, 9))
                0:       id = '0;
                1, 2:    id = ID_W'($urandom_range(0, SLOTS - 1));
                default: id = ID_W'($urandom_range(1, 20));
            endcase
        end
        else if (pick < 65)
        begin
            op      = OP_ADVANCE;
            elapsed = rand_elapsed();
        end
        else if (pick < 85)
            op = OP_RUN;
        else if (pick < 95)
            op = OP_NEXT;
        else
            op = OP_Format_undef();
        queue_cmd(op, delay, $urandom(), id, elapsed, 1'b0);
    endtask

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR at %0t ns, result %0d: %s", $time, resp_total, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Request driver: waits out each item's gap, then holds valid until the transfer.
    always @(posedge clk or negedge rst_n)
    begin
        bit accepted;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            idle_waited  <= 0;
            sent_total   <= 0;
        end
        else
        begin
            accepted = req_ch.valid && req_ch.ready;
            if (accepted)
            begin
                expected_rsps.push_back(apply_timer_cmd(cur_cmd));
                op_seen[cur_cmd.op]++;
                sent_total <= sent_total + 1;
            end

            if (req_ch.valid && !req_ch.ready)
            begin
                // Hold the current item until it is taken.
            end
            else if (pending_cmds.size() == 0 ||
                     (pending_cmds[0].drain_first &&
                      sent_total + int'(accepted) != resp_total))
                req_ch.valid <= 1'b0;
            else if (idle_waited < pending_cmds[0].gap)
            begin
                req_ch.valid <= 1'b0;
                idle_waited  <= idle_waited + 1;
            end
            else
            begin
                cur_cmd            = pending_cmds.pop_front();
                req_ch.op         <= cur_cmd.op;
                req_ch.delay_ms   <= cur_cmd.delay_ms;
                req_ch.tag        <= cur_cmd.tag;
                req_ch.slot_id    <= cur_cmd.slot_id;
                req_ch.elapsed_ms <= cur_cmd.elapsed_ms;
                req_ch.valid      <= 1'b1;
                idle_waited       <= 0;
            end
        end
    end

    // Result monitor: checks each transfer against the oldest expectation, then may stall.
    always @(posedge clk or negedge rst_n)
    begin
        timer_rsp_t want;
        int         stall;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            resp_total   <= 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
                report_error("result transfer with no request waiting for it");
            else
            begin
                want = expected_rsps.pop_front();
                check_field("status", rsp_ch.status, want.status);
                check_field("slot_out", rsp_ch.slot_out, want.slot_out);
                check_field("tag_out", rsp_ch.tag_out, want.tag_out);
                check_field("remaining_ms", rsp_ch.remaining_ms, want.remaining_ms);
                check_field("table_full", rsp_ch.table_full, want.table_full);
            end
            resp_total <= resp_total + 1;
            // Every fifth stretch of 200 results is taken without stalls.
            stall = ((resp_total / 200) % 5 == 3) ? 0 : $urandom_range(0, 3);
            rsp_ch.ready <= (stall == 0);
            stall_left   <= stall;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int i;
        int k;
        int n;
        logic [ID_W-1:0] id;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_SCHEDULE;
        req_ch.delay_ms   = '0;
        req_ch.tag        = '0;
        req_ch.slot_id    = '0;
        req_ch.elapsed_ms = '0;
        rsp_ch.ready      = 1'b0;

        table_now = '0;
        for (i = 0; i < SLOTS; i++)
        begin
            table_busy[i]   = 1'b0;
            table_expiry[i] = '0;
            table_tag[i]    = '0;
        end

        // Directed: empty table, slot 0 and free-slot deletes, zero and maximum delays,
        // firing order, full-size advance and undefined ops with every field bit set.
        queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_DELETE, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_DELETE, '0, '0, ID_W'(SLOTS - 1), '0, 1'b0);
        queue_cmd(OP_SCHEDULE, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_SCHEDULE, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_RUN, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_NEXT, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_ADVANCE, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_ADVANCE, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_UNDEF_LO, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_UNDEF_LO + 3'd1, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_UNDEF_HI, '1, '1, '1, '1, 1'b0);
        queue_cmd(OP_SCHEDULE, DELAY_W'(1), 32'hA5A5_A5A5, '1, '1, 1'b0);
        queue_cmd(OP_ADVANCE, '0, '0, '0, ELAPSED_W'(1), 1'b0);
        queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_DELETE, '1, '1, ID_W'(2), '1, 1'b0);
        queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);

        // Random part: bursts of mixed traffic and occasional fill-and-drain sequences.
        n = queued_count + RANDOM_ITEMS;
        while (queued_count < n)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                // Fill the table, often past the top, then delete all slots or run timers off.
                k = $urandom_range(SLOTS - 8, SLOTS + 12);
                queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b1);
                for (i = 0; i < k; i++)
                begin
                    queue_cmd(OP_SCHEDULE, DELAY_W'($urandom_range(0, 200000)), $urandom(),
                              ID_W'($urandom()), ELAPSED_W'($urandom()), 1'b0);
                end
                queue_cmd(OP_SCHEDULE, rand_delay(), $urandom(), '0, '0, 1'b0);
                queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);
                queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
                if ($urandom_range(0, 1) == 0)
                begin
                    for (i = 0; i < SLOTS; i++)
                    begin
                        id = ID_W'(i);
                        queue_cmd(OP_DELETE, DELAY_W'($urandom()), $urandom(), id,
                                  ELAPSED_W'($urandom()), 1'b0);
                    end
                end
                else
                begin
                    repeat (8) queue_cmd(OP_ADVANCE, '0, '0, '0, '1, 1'b0);
                    repeat (SLOTS + 2) queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
                end
            end
            else
            begin
                k = $urandom_range(20, 80);
                repeat (k) queue_random_cmd();
            end
        end

        // Long timers under a run of full-size advances, with the sender drained first.
        queue_cmd(OP_SCHEDULE, '1, $urandom(), '0, '0, 1'b1);
        queue_cmd(OP_SCHEDULE, DELAY_W'(32'h4000_0000), $urandom(), '0, '0, 1'b0);
        queue_cmd(OP_SCHEDULE, DELAY_W'(5), $urandom(), '0, '0, 1'b0);
        for (k = 0; k < WRAP_STEPS; k++)
        begin
            queue_cmd(OP_ADVANCE, '0, '0, '0, '1, 1'b0);
            if (k % 32 == 0)
            begin
                queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);
                queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
                queue_cmd(OP_SCHEDULE, rand_delay(), $urandom(), '0, '0, 1'b0);
            end
        end
        repeat (6) queue_cmd(OP_RUN, '0, '0, '0, '0, 1'b0);
        queue_cmd(OP_NEXT, '0, '0, '0, '0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (resp_total != queued_count)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_rsps.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_rsps.size()));

        $display("Requests: %0d schedule, %0d delete, %0d advance, %0d run, %0d next, %0d other",
                 op_seen[OP_SCHEDULE], op_seen[OP_DELETE], op_seen[OP_ADVANCE],
                 op_seen[OP_RUN], op_seen[OP_NEXT],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("Results: %0d checked, %0d timers fired, %0d refused as full, %0d clock wraps",
                 resp_total, fired_count, refused_count, wrap_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
